[rtl/prp_pkg.sv]
`default_nettype none

package prp_pkg;

  localparam int unsigned PALETTE_DEPTH = 512;
  localparam int unsigned PTR_W         = $clog2(PALETTE_DEPTH);
  localparam int unsigned ENTRY_W       = 9;

  // register map, low three address bits
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_PTR_LO = 3'd2;
  localparam logic [2:0] REG_PTR_HI = 3'd3;
  localparam logic [2:0] REG_ENT_LO = 3'd4;
  localparam logic [2:0] REG_ENT_HI = 3'd5;

  localparam logic [7:0] RD_IDLE    = 8'hFF;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // zero one palette entry, step the sweep
    logic load;   // take a request, start the palette read
    logic exec;   // commit the request and load the result register
  } prp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // sweep is at the final entry
    logic out_busy;  // result register full and not taken this cycle
  } prp_sts_t;

  function automatic logic [2:0] divider_for(input logic [1:0] speed);
    logic [2:0] div;
    case (speed)
      2'd0:    div = 3'd4;
      2'd1:    div = 3'd3;
      default: div = 3'd2;
    endcase
    return div;
  endfunction

endpackage

`default_nettype wire

[rtl/prp_ctrl.sv]
`default_nettype none

module prp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire prp_pkg::prp_sts_t sts_i,
  output prp_pkg::prp_cmd_t     cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait here while the previous result is still unclaimed
        if (!sts_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/prp_dp.sv]
`default_nettype none

module prp_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prp_pkg::prp_cmd_t cmd_i,
  output prp_pkg::prp_sts_t      sts_o,
  input  wire logic              req_type_i,
  input  wire logic [2:0]        reg_addr_i,
  input  wire logic [7:0]        write_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             read_data_o,
  output logic [1:0]             speed_mode_o,
  output logic [2:0]             clock_divider_o,
  output logic                   blur_on_o,
  output logic                   mono_on_o,
  output logic                   speed_changed_seen_o,
  output logic [prp_pkg::PTR_W-1:0] pointer_now_o
);

  logic [prp_pkg::ENTRY_W-1:0] mem [prp_pkg::PALETTE_DEPTH];

  logic [prp_pkg::PTR_W-1:0]   clr_cnt_q;
  logic [prp_pkg::PTR_W-1:0]   ptr_q, ptr_d;
  logic [7:0]                  ctrl_q, ctrl_d;
  logic                        flag_q, flag_d;
  logic [prp_pkg::ENTRY_W-1:0] rdata_q;
  logic                        req_type_q;
  logic [2:0]                  reg_addr_q;
  logic [7:0]                  wdata_q;
  logic                        out_valid_q;

  logic                        ent_we;
  logic [prp_pkg::ENTRY_W-1:0] ent_new;
  logic [7:0]                  rd;
  logic                        mem_we;
  logic [prp_pkg::PTR_W-1:0]   mem_wa;
  logic [prp_pkg::ENTRY_W-1:0] mem_wd;

  assign sts_o.clr_last = &clr_cnt_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // request decode, acting on the entry read at the pointer
  always_comb begin
    ctrl_d  = ctrl_q;
    flag_d  = flag_q;
    ptr_d   = ptr_q;
    ent_we  = 1'b0;
    ent_new = rdata_q;
    rd      = prp_pkg::RD_IDLE;
    if (req_type_q) begin
      unique case (reg_addr_q)
        prp_pkg::REG_CTRL: begin
          if (wdata_q[1:0] != ctrl_q[1:0]) flag_d = 1'b1;
          ctrl_d = wdata_q;
        end
        prp_pkg::REG_PTR_LO: ptr_d = {ptr_q[8], wdata_q};
        prp_pkg::REG_PTR_HI: ptr_d = {wdata_q[0], ptr_q[7:0]};
        prp_pkg::REG_ENT_LO: begin
          ent_we  = 1'b1;
          ent_new = {rdata_q[8], wdata_q};
        end
        prp_pkg::REG_ENT_HI: begin
          ent_we  = 1'b1;
          ent_new = {wdata_q[0], rdata_q[7:0]};
          ptr_d   = ptr_q + 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (reg_addr_q)
        prp_pkg::REG_ENT_LO: rd = rdata_q[7:0];
        prp_pkg::REG_ENT_HI: begin
          rd    = {7'h7F, rdata_q[8]};
          ptr_d = ptr_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign mem_we = cmd_i.clear || (cmd_i.exec && ent_we);
  assign mem_wa = cmd_i.clear ? clr_cnt_q : ptr_q;
  assign mem_wd = cmd_i.clear ? '0 : ent_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.load) rdata_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      reg_addr_q <= reg_addr_i;
      wdata_q    <= write_data_i;
    end
    if (cmd_i.exec) begin
      read_data_o          <= rd;
      speed_mode_o         <= ctrl_d[1:0];
      clock_divider_o      <= prp_pkg::divider_for(ctrl_d[1:0]);
      blur_on_o            <= ctrl_d[2];
      mono_on_o            <= ctrl_d[7];
      speed_changed_seen_o <= flag_d;
      pointer_now_o        <= ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      ptr_q       <= '0;
      ctrl_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.exec) begin
        ptr_q       <= ptr_d;
        ctrl_q      <= ctrl_d;
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/palette_ram_register_port_unit.sv]
`default_nettype none

// Palette RAM register port. Each request on the slave stream is one bus
// access (tuser: 0 read, 1 write) to register 0..7; each gives exactly one
// response on the master stream with the read byte and a snapshot of the
// control byte, sticky speed-change flag and table pointer after the access.
// Map: 0 control (bits 1:0 speed, 2 blur, 7 mono), 2/3 pointer low/bit 8,
// 4/5 palette entry low byte/bit 8 at the pointer; any access to 5 steps the
// pointer modulo 512. Unused registers and all writes read back 0xFF.
// Timing: after reset the 512-entry palette RAM is swept to zero, one entry
// per cycle, and tready stays low until the sweep is done. After that each
// request first does the registered palette RAM read, then applies the
// read-modify-write and loads the response register. A new request is taken
// only once the last has committed. A response waiting on tready does not
// block the next request from being taken, only its commit.

module palette_ram_register_port_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [2:0] reg_addr, [10:3] write_data, rest 0
  input  wire logic        s_axis_tuser,  // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // [7:0] read_data, [9:8] speed_mode,
                                          // [12:10] clock_divider, [13] blur_on,
                                          // [14] mono_on, [15] speed_changed_seen,
                                          // [24:16] pointer_now, rest 0
);

  prp_pkg::prp_cmd_t cmd;
  prp_pkg::prp_sts_t sts;

  logic [7:0]                read_data;
  logic [1:0]                speed_mode;
  logic [2:0]                clock_divider;
  logic                      blur_on;
  logic                      mono_on;
  logic                      speed_changed_seen;
  logic [prp_pkg::PTR_W-1:0] pointer_now;

  prp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  prp_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_type_i           (s_axis_tuser),
    .reg_addr_i           (s_axis_tdata[2:0]),
    .write_data_i         (s_axis_tdata[10:3]),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .read_data_o          (read_data),
    .speed_mode_o         (speed_mode),
    .clock_divider_o      (clock_divider),
    .blur_on_o            (blur_on),
    .mono_on_o            (mono_on),
    .speed_changed_seen_o (speed_changed_seen),
    .pointer_now_o        (pointer_now)
  );

  assign m_axis_tdata = {7'd0, pointer_now, speed_changed_seen, mono_on, blur_on,
                         clock_divider, speed_mode, read_data};

`ifndef ASSERT_OFF
  // one request in flight: a taken request closes the input next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a commit always presents a response
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> m_axis_tvalid)
    else $error("commit without response");

  // no response can appear during the palette sweep
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> (!m_axis_tvalid && !s_axis_tready))
    else $error("activity during palette sweep");

  // a commit never overwrites an unclaimed response
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !cmd.exec)
    else $error("response overwritten");
`endif

endmodule

`default_nettype wire
